### hw/rtl/kit_pkg.sv
package kit_pkg;

    localparam int KEY_W           = 64;
    localparam int IDX_W           = 9;
    localparam int ENTRIES_DEFAULT = 256;

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_INSERT = 1'b1
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [KEY_W-1:0]   key;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]   entry_index;
        logic               found;
        logic               full_res;
        logic [IDX_W-1:0]   pool_count;
    } out_t;

endpackage

### hw/rtl/key_interning_table.sv
// Each beat reads then compares the stored entries in order (S_READ, S_CMP);
// a hit goes to S_DONE, a miss through S_MISS (insert or full) to S_DONE, which
// delivers once the output register is free. One beat in flight; the next beat is
// accepted the cycle after the result is loaded into the output register. Rate is
// set by the single key memory read port feeding the one 64-bit comparator.
// Reset clears the fill count (pool size returns to 1); key memory is not cleared.
module key_interning_table #(
    parameter int ENTRIES = kit_pkg::ENTRIES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  kit_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output kit_pkg::out_t out_data
);
    import kit_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_CMP  = 5'b00100,
        S_MISS = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;   // stored entries; slots below it are valid
    logic [CW-1:0]    scan_reg, scan_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_reg, out_next;
    action_t          act_reg, act_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             hit_reg, hit_next;
    logic             full_reg, full_next;

    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [KEY_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [CW:0]      scan_inc;
    logic [CW:0]      count_inc;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign scan_inc  = {1'b0, scan_reg} + 1'b1;
    assign count_inc = {1'b0, count_reg} + 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[count_reg[AW-1:0]] <= key_reg;
        end
        rd_data_reg <= key_mem[scan_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        full_next      = full_reg;
        mem_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next  = in_data.action;
                    key_next  = in_data.key;
                    scan_next = '0;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    full_next = 1'b0;
                    state_next = (count_reg == '0) ? S_MISS : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    hit_next   = 1'b1;
                    idx_next   = IDX_W'(scan_inc);
                    state_next = S_DONE;
                end
                else if (scan_inc == {1'b0, count_reg})
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    scan_next  = scan_inc[CW-1:0];
                    state_next = S_READ;
                end
            end
            S_MISS:
            begin
                if (act_reg == ACT_INSERT)
                begin
                    if (count_reg < CW'(ENTRIES))
                    begin
                        mem_we     = 1'b1;
                        idx_next   = IDX_W'(count_inc);
                        count_next = count_inc[CW-1:0];
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.entry_index = idx_reg;
                    out_next.found       = hit_reg;
                    out_next.full_res    = full_reg;
                    out_next.pool_count  = IDX_W'(count_inc);
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        out_reg  <= out_next;
        act_reg  <= act_next;
        key_reg  <= key_next;
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        full_reg <= full_next;
    end

endmodule

### sim/key_interning_table_test.sv
module key_interning_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import kit_pkg::*;

    localparam int TABLE_DEPTH  = ENTRIES_DEFAULT;
    localparam int RANDOM_ITEMS = 1035;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
    localparam int LONG_HOLD    = 800;

    class intern_pool_model;
        logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
        bit               slot_used [TABLE_DEPTH];
        logic [IDX_W-1:0] slot_idx [TABLE_DEPTH];
        logic [IDX_W-1:0] next_idx;
        out_t             awaited_results [$];
        logic [KEY_W-1:0] stored_keys [$];
        logic [KEY_W-1:0] absent_keys [$];
        int               hits;
        int               inserts;
        int               misses;
        int               rejects;
        int               mismatches;

        function new();
            next_idx = 1;
        endfunction

        function void note_request(in_t req);
            out_t want;
            bit   hit;
            int   slot;
            want = '0;
            hit  = 1'b0;
            for (slot = 0; slot < TABLE_DEPTH && !hit; slot++)
                if (slot_used[slot] && key_mem[slot] == req.key)
                begin
                    hit = 1'b1;
                    want.entry_index = slot_idx[slot];
                end
            if (hit)
                hits++;
            else if (req.action == ACT_INSERT)
            begin
                // entry k lives in slot k-1
                slot = int'(next_idx) - 1;
                if (slot < TABLE_DEPTH)
                begin
                    key_mem[slot]    = req.key;
                    slot_idx[slot]   = next_idx;
                    slot_used[slot]  = 1'b1;
                    want.entry_index = next_idx;
                    next_idx++;
                    inserts++;
                    stored_keys.push_back(req.key);
                end
                else
                begin
                    want.full_res = 1'b1;
                    rejects++;
                    absent_keys.push_back(req.key);
                end
            end
            else
            begin
                misses++;
                absent_keys.push_back(req.key);
            end
            want.found      = hit;
            want.pool_count = next_idx;
            awaited_results.push_back(want);
        endfunction

        task report_mismatch(string field, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
            mismatches++;
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, want, got);
        endtask

        task check_reply(out_t got);
            out_t want;
            if (awaited_results.size() == 0)
            begin
                report_mismatch("unexpected beat (entry_index)", '0, got.entry_index);
                return;
            end
            want = awaited_results.pop_front();
            if (got.entry_index !== want.entry_index)
                report_mismatch("entry_index", want.entry_index, got.entry_index);
            if (got.found !== want.found)
                report_mismatch("found", IDX_W'(want.found), IDX_W'(got.found));
            if (got.full_res !== want.full_res)
                report_mismatch("full_res", IDX_W'(want.full_res), IDX_W'(got.full_res));
            if (got.pool_count !== want.pool_count)
                report_mismatch("pool_count", want.pool_count, got.pool_count);
        endtask
    endclass

    logic   clk;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   in_ready;
    in_t    in_data   = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    out_t   out_data;

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     long_hold_req = 1'b0;
    int     cycle_count   = 0;

    intern_pool_model pool = new();

    key_interning_table #(
        .ENTRIES (TABLE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            pool.note_request(in_data);
        if (rst_n && out_valid && out_ready)
            pool.check_reply(out_data);
    end

    // receiver; a long hold lets the block fill and back up its input
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pool.awaited_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // valid stays high between back-to-back beats; it only drops on a gap
    task automatic send_request(input action_t act, input logic [KEY_W-1:0] k);
        in_t req;
        req.action = act;
        req.key    = k;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int left);
        int               roll;
        int               free_slots;
        action_t          act;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] one_hot;
        free_slots = TABLE_DEPTH + 1 - int'(pool.next_idx);
        roll       = $urandom_range(99);
        act        = action_t'($urandom_range(1));
        one_hot    = '0;
        one_hot[$urandom_range(KEY_W-1)] = 1'b1;
        // make sure the table reaches full well before the end
        if (roll < 40 || (free_slots > 0 && left <= free_slots + 150))
        begin
            k   = random_key();
            act = ACT_INSERT;
        end
        else if (roll < 65 && pool.stored_keys.size() > 0)
            k = pool.stored_keys[$urandom_range(pool.stored_keys.size() - 1)];
        else if (roll < 75)
        begin
            k   = random_key();
            act = ACT_LOOKUP;
        end
        else if (roll < 85 && pool.stored_keys.size() > 0)
            // near miss: stored key with a single bit flipped
            k = pool.stored_keys[$urandom_range(pool.stored_keys.size() - 1)] ^ one_hot;
        else if (roll < 95 && pool.absent_keys.size() > 0)
            k = pool.absent_keys[$urandom_range(pool.absent_keys.size() - 1)];
        else
        begin
            case ($urandom_range(3))
                0:       k = '0;
                1:       k = '1;
                2:       k = one_hot;
                default: k = ~one_hot;
            endcase
        end
        send_request(act, k);
    endtask

    initial
    begin
        int n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 22;
        recv_idle_pct = 63;

        send_request(ACT_LOOKUP, 64'h0000_0000_0000_0000);  // miss on empty table
        send_request(ACT_INSERT, 64'h0000_0000_0000_0000);
        send_request(ACT_LOOKUP, 64'h0000_0000_0000_0000);
        send_request(ACT_INSERT, 64'h0000_0000_0000_0000);  // hit on insert
        send_request(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE);
        send_request(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_INSERT, 64'h8000_0000_0000_0000);
        send_request(ACT_INSERT, 64'h0000_0000_0000_0001);
        send_request(ACT_LOOKUP, 64'h0000_0000_0000_0001);
        send_request(ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(ACT_INSERT, 64'h5555_5555_5555_5555);
        send_request(ACT_LOOKUP, 64'h5555_5555_5555_5555);
        send_request(ACT_LOOKUP, 64'h0000_0000_0000_0000);
        send_request(ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 22;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                long_hold_req = 1'b1;
            end
            send_random(RANDOM_ITEMS - n);
        end
        in_valid <= 1'b0;

        while (pool.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests in %0d cycles: %0d hits, %0d new entries, %0d lookup misses,",
                 pool.hits + pool.inserts + pool.misses + pool.rejects, cycle_count,
                 pool.hits, pool.inserts, pool.misses);
        $display("%0d inserts refused on a full table; pool size ended at %0d, %0d mismatches",
                 pool.rejects, pool.next_idx, pool.mismatches);
        if (pool.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### key_interning_table.f
hw/rtl/kit_pkg.sv
hw/rtl/key_interning_table.sv
sim/key_interning_table_test.sv
